// ===== hdl/sra_pkg.sv =====
// Shared types and constants for the selective-repeat ARQ sender.
// Holds item, result, command and config structs, operation/result codes, register indexes,
// engine states, sizes and reset values. No dependencies.
package sra_pkg;

  // Defaults and fixed sizes
  localparam int unsigned SeqCountDef = 8;
  localparam int unsigned MaxRetx     = 8;   // most retransmits per tick
  localparam int unsigned CmdQDepth   = 2;
  localparam int unsigned ResQDepth   = 2;
  localparam int unsigned StampW      = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [2:0]  WindowSizeRst   = 3'd4;
  localparam logic [15:0] TimeoutTicksRst = 16'd1000;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_TX_NEW    = 3'd0,
    KIND_WIN_FULL  = 3'd1,
    KIND_ACK_TAKEN = 3'd2,
    KIND_ACK_IGN   = 3'd3,
    KIND_RETX      = 3'd4,
    KIND_TICK_IDLE = 3'd5
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1
  } cfg_reg_e;

  // Command classes passed from front to engine
  typedef enum logic [1:0] {
    CMD_SEND,
    CMD_ACK,
    CMD_TICK
  } cmd_e;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_WALK,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_FIN
  } eng_state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] seq_number;
    logic [2:0] window_start;
    logic [2:0] pending_count;
    logic       last;
  } result_t;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] ack_seq;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  win_size;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== hdl/sra_front.sv =====
// Front end: decodes input items into commands and queues them.
// Depends on sra_pkg.
module sra_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  sra_pkg::in_item_t item_i,
  output logic            cmd_valid_o,
  output sra_pkg::cmd_t   cmd_o,
  input  logic            cmd_pop_i
);
  import sra_pkg::*;

  localparam int unsigned PtrW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CmdQDepth - 1);

  cmd_t            mem_q [CmdQDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cmd_t            cmd_new;
  logic            cmd_keep;
  logic            accept, do_wr, do_rd;

  // Classify: operation three is dropped
  always_comb begin
    cmd_new.ack_seq = item_i.ack_seq;
    cmd_new.op      = CMD_SEND;
    cmd_keep        = 1'b1;
    case (item_i.operation)
      OP_SEND: cmd_new.op = CMD_SEND;
      OP_ACK:  cmd_new.op = CMD_ACK;
      OP_TICK: cmd_new.op = CMD_TICK;
      default: cmd_keep   = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == CntW'(CmdQDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign accept      = push_i && !full_o;
  assign do_wr       = accept && cmd_keep;
  assign do_rd       = cmd_pop_i && cmd_valid_o;

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_rd) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/sra_res_queue.sv =====
// Result queue between the engine and the result ports.
// Depends on sra_pkg.
module sra_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  sra_pkg::result_t res_i,
  output logic             empty_o,
  input  logic             pop_i,
  output sra_pkg::result_t res_o
);
  import sra_pkg::*;

  localparam int unsigned PtrW = (ResQDepth > 1) ? $clog2(ResQDepth) : 1;
  localparam int unsigned CntW = $clog2(ResQDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(ResQDepth - 1);

  result_t         mem_q [ResQDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(ResQDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_rd) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

// ===== hdl/sra_engine.sv =====
// Back end: window state, timer stamps and the command sequencer.
// Executes send, ack and tick commands and pushes results. Depends on sra_pkg.
module sra_engine #(
  parameter int unsigned SEQ_COUNT = sra_pkg::SeqCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sra_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  sra_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output sra_pkg::result_t res_o
);
  import sra_pkg::*;

  localparam int unsigned SW   = $clog2(SEQ_COUNT);
  localparam int unsigned CntW = $clog2(SEQ_COUNT + 1);
  localparam int unsigned HitW = $clog2(MaxRetx + 1);
  localparam logic [SW-1:0]   LastIdx = SW'(SEQ_COUNT - 1);
  localparam logic [HitW-1:0] HitLast = HitW'(MaxRetx - 1);

  eng_state_e        state_q, state_d;
  logic [SEQ_COUNT-1:0] pend_q, pend_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SW-1:0]     base_q, base_d;
  logic [SW-1:0]     next_q, next_d;
  logic [StampW-1:0] time_q, time_d;
  logic [SW-1:0]     idx_q, idx_d;
  logic [HitW-1:0]   hits_q, hits_d;
  logic [SW-1:0]     held_q, held_d;
  logic              held_vld_q, held_vld_d;

  logic [StampW-1:0] stamp_mem [SEQ_COUNT];
  logic [StampW-1:0] stamp_rd_q;
  logic              mem_we;
  logic [SW-1:0]     mem_waddr;

  logic [SW-1:0]     ack_idx;
  logic              ack_hit, send_ok, walk_stop, expired, scan_end;
  logic [StampW-1:0] age;

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
    seq_inc = (s == LastIdx) ? '0 : s + 1'b1;
  endfunction

  // Shared decisions
  assign ack_idx   = SW'(cmd_i.ack_seq);
  assign ack_hit   = (int'(cmd_i.ack_seq) < SEQ_COUNT) && pend_q[ack_idx];
  assign send_ok   = (32'(count_q) < 32'(cfg_i.win_size)) && !pend_q[next_q];
  assign walk_stop = pend_q[base_q] || (base_q == next_q);
  assign age       = time_q - stamp_rd_q;
  assign expired   = !age[StampW-1] && (age >= StampW'(cfg_i.timeout_ticks));
  assign scan_end  = (idx_q == LastIdx);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            CMD_ACK:  if (ack_hit) state_d = ST_ACK_WALK;
            CMD_TICK: state_d = ST_TICK_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACK_WALK: begin
        if (walk_stop && !res_full_i) state_d = ST_IDLE;
      end
      ST_TICK_RD: begin
        if (pend_q[idx_q]) begin
          state_d = ST_TICK_CHK;
        end else if (scan_end) begin
          state_d = ST_TICK_FIN;
        end
      end
      ST_TICK_CHK: begin
        if (expired) begin
          if (!(held_vld_q && res_full_i)) begin
            state_d = (scan_end || hits_q == HitLast) ? ST_TICK_FIN : ST_TICK_RD;
          end
        end else begin
          state_d = scan_end ? ST_TICK_FIN : ST_TICK_RD;
        end
      end
      ST_TICK_FIN: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pend_d     = pend_q;
    count_d    = count_q;
    base_d     = base_q;
    next_d     = next_q;
    time_d     = time_q;
    idx_d      = idx_q;
    hits_d     = hits_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.kind          = KIND_TICK_IDLE;
    res_o.seq_number    = '0;
    res_o.window_start  = 3'(base_q);
    res_o.pending_count = 3'(count_q);
    res_o.last          = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            CMD_SEND: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                if (send_ok) begin
                  res_o.kind          = KIND_TX_NEW;
                  res_o.seq_number    = 3'(next_q);
                  res_o.pending_count = 3'(count_q + 1'b1);
                  pend_d[next_q]      = 1'b1;
                  count_d             = count_q + 1'b1;
                  next_d              = seq_inc(next_q);
                  mem_we              = 1'b1;
                  mem_waddr           = next_q;
                end else begin
                  res_o.kind = KIND_WIN_FULL;
                end
              end
            end
            CMD_ACK: begin
              if (ack_hit) begin
                pend_d[ack_idx] = 1'b0;
                count_d         = count_q - 1'b1;
              end else if (!res_full_i) begin
                res_push_o       = 1'b1;
                cmd_pop_o        = 1'b1;
                res_o.kind       = KIND_ACK_IGN;
                res_o.seq_number = cmd_i.ack_seq;
              end
            end
            CMD_TICK: begin
              time_d     = time_q + 1'b1;
              idx_d      = '0;
              hits_d     = '0;
              held_vld_d = 1'b0;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      // Slide the base over cleared entries, one per cycle
      ST_ACK_WALK: begin
        if (walk_stop) begin
          if (!res_full_i) begin
            res_push_o       = 1'b1;
            cmd_pop_o        = 1'b1;
            res_o.kind       = KIND_ACK_TAKEN;
            res_o.seq_number = cmd_i.ack_seq;
          end
        end else begin
          base_d = seq_inc(base_q);
        end
      end
      ST_TICK_RD: begin
        if (!pend_q[idx_q] && !scan_end) begin
          idx_d = idx_q + 1'b1;
        end
      end
      // Timer check; previous hit goes out once the next one is known
      ST_TICK_CHK: begin
        if (expired) begin
          if (!(held_vld_q && res_full_i)) begin
            res_push_o       = held_vld_q;
            res_o.kind       = KIND_RETX;
            res_o.seq_number = 3'(held_q);
            res_o.last       = 1'b0;
            mem_we           = 1'b1;
            held_d           = idx_q;
            held_vld_d       = 1'b1;
            hits_d           = hits_q + 1'b1;
            if (!scan_end) idx_d = idx_q + 1'b1;
          end
        end else if (!scan_end) begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TICK_FIN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          cmd_pop_o  = 1'b1;
          if (held_vld_q) begin
            res_o.kind       = KIND_RETX;
            res_o.seq_number = 3'(held_q);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_q     <= '0;
      count_q    <= '0;
      base_q     <= '0;
      next_q     <= '0;
      time_q     <= '0;
      idx_q      <= '0;
      hits_q     <= '0;
      held_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      count_q    <= count_d;
      base_q     <= base_d;
      next_q     <= next_d;
      time_q     <= time_d;
      idx_q      <= idx_d;
      hits_q     <= hits_d;
      held_vld_q <= held_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // Send-stamp memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stamp_mem[mem_waddr] <= time_q;
    end
    stamp_rd_q <= stamp_mem[idx_q];
  end

  // Checks
  a_count_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(pend_q))
    else $error("pending count out of step with flags");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command popped from empty queue");

  a_hits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hits_q) <= MaxRetx)
    else $error("too many retransmits in one tick");

  a_tick_advances_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d == ST_TICK_RD) |=> time_q == $past(time_q) + 1'b1)
    else $error("tick did not advance time");

endmodule

// ===== hdl/selective_repeat_arq_sender.sv =====
// Selective-repeat ARQ sender window keeper (top level).
// Each result passes through the command queue, the engine and the result queue, both
// queues registered. Send and ignored ack are done in the engine idle state; taken ack walks
// the base one entry per cycle while it slides; tick reads and checks each pending entry,
// skips idle ones, then finishes. Rate is set by the engine sequencer and the stamp memory read port.
// Async active-low reset clears window state, time and queues and restores the
// configuration defaults; stamps are not cleared.
module selective_repeat_arq_sender #(
  parameter int unsigned SEQ_COUNT = sra_pkg::SeqCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  sra_pkg::in_item_t             item_i,
  output logic                          empty,
  input  logic                          pop,
  output sra_pkg::result_t              result_o,
  input  logic                          cfg_we_i,
  input  logic [sra_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sra_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sra_pkg::*;

  cfg_t    cfg_q;
  logic    cmd_valid, cmd_pop, res_push, res_full;
  cmd_t    cmd;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_size      <= WindowSizeRst;
      cfg_q.timeout_ticks <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_SIZE:   cfg_q.win_size      <= cfg_data_i[2:0];
        REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  sra_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sra_engine #(
    .SEQ_COUNT (SEQ_COUNT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  sra_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .res_i   (res),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (result_o)
  );

endmodule
